// ----- rtl/tcaa_pkg.sv -----
// Shared types and constants for the two-class alternating arbiter.
// Depends on nothing; imported by two_class_alternating_arbiter and its testbench.
package tcaa_pkg;

   localparam int ID_W       = 8;   // width of an identity on the ports
   localparam int HOLDER_W   = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // item kind, carried in req_tuser
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // holder state codes
   localparam logic [HOLDER_W-1:0] HOLDER_FREE = 2'd0;
   localparam logic [HOLDER_W-1:0] HOLDER_CAT0 = 2'd1;
   localparam logic [HOLDER_W-1:0] HOLDER_CAT1 = 2'd2;

   typedef struct packed {
      logic [HOLDER_W-1:0] holder_state;
      logic                release_error;
      logic                rejected;
      logic                grant_category;
      logic [ID_W-1:0]     grant_id;
      logic                grant_valid;
   } result_type;

endpackage

// ----- rtl/two_class_alternating_arbiter.sv -----
// Two-class alternating arbiter: one request/release transfer per cycle while rsp_tready does not stall.
// Latency: a result appears on rsp_* the cycle after its request is accepted.
// Throughput: one transfer per cycle unless a pending result is stalled by rsp_tready; the single result
// register and the per-category FIFO pointers are updated together at the accepting edge.
// Reset (synchronous, active high): resource free, both FIFOs empty, no
// result pending. FIFO storage is not cleared; empty entries are never read.
// Depends on tcaa_pkg.
module two_class_alternating_arbiter
   import tcaa_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] request_category, [8:1] requester_id, [15:9] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] grant_valid, [8:1] grant_id, [9] grant_category, [10] rejected,
   // [11] release_error, [13:12] holder_state, [15:14] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Identities are kept in at most the port width.
   localparam int STORE_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   // Arbitration state
   logic             busy_ff, busy_in;
   logic             owner_ff, owner_in;
   logic [PTR_W-1:0] head_ff  [2];
   logic [PTR_W-1:0] head_in  [2];
   logic [PTR_W-1:0] tail_ff  [2];
   logic [PTR_W-1:0] tail_in  [2];
   logic [CNT_W-1:0] count_ff [2];
   logic [CNT_W-1:0] count_in [2];

   // FIFO storage, one memory per category, and the prefetched head entries
   logic [STORE_W-1:0] queue_mem_ff  [2][QUEUE_DEPTH];
   logic [STORE_W-1:0] head_data_ff  [2];

   // Result register
   logic       rsp_valid_ff;
   result_type rsp_ff, rsp_in;

   logic               accept;
   logic               kind;
   logic               cat;
   logic [STORE_W-1:0] id_stored;
   logic [1:0]         push;
   logic [1:0]         pop;
   logic               other;

   // Take a new transfer whenever the result register is empty or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign kind      = req_tuser;
   assign cat       = req_tdata[0];
   assign id_stored = req_tdata[STORE_W:1];
   assign other     = ~owner_ff;

   // Decide the grant, queue or reject for this transfer.
   always_comb begin
      push     = 2'b00;
      pop      = 2'b00;
      busy_in  = busy_ff;
      owner_in = owner_ff;
      rsp_in   = '0;
      if (accept) begin
         if (kind == KIND_REQUEST) begin
            if (!busy_ff) begin
               // resource free: grant at once
               busy_in               = 1'b1;
               owner_in              = cat;
               rsp_in.grant_valid    = 1'b1;
               rsp_in.grant_id       = ID_W'(id_stored);
               rsp_in.grant_category = cat;
            end else if (count_ff[cat] == FULL_CNT) begin
               rsp_in.rejected = 1'b1;
            end else begin
               push[cat] = 1'b1;
            end
         end else begin
            if (!busy_ff) begin
               rsp_in.release_error = 1'b1;
            end else if (count_ff[other] != '0) begin
               // alternate: prefer the other category's head
               pop[other]            = 1'b1;
               owner_in              = other;
               rsp_in.grant_valid    = 1'b1;
               rsp_in.grant_id       = ID_W'(head_data_ff[other]);
               rsp_in.grant_category = other;
            end else if (count_ff[owner_ff] != '0) begin
               pop[owner_ff]         = 1'b1;
               rsp_in.grant_valid    = 1'b1;
               rsp_in.grant_id       = ID_W'(head_data_ff[owner_ff]);
               rsp_in.grant_category = owner_ff;
            end else begin
               busy_in = 1'b0;
            end
         end
      end
      if (!busy_in) begin
         rsp_in.holder_state = HOLDER_FREE;
      end else if (owner_in) begin
         rsp_in.holder_state = HOLDER_CAT1;
      end else begin
         rsp_in.holder_state = HOLDER_CAT0;
      end
   end

   // Advance FIFO pointers; a single transfer never pushes and pops one queue.
   always_comb begin
      for (int q = 0; q < 2; q++) begin
         head_in[q]  = head_ff[q];
         tail_in[q]  = tail_ff[q];
         count_in[q] = count_ff[q];
         if (pop[q]) begin
            head_in[q]  = (head_ff[q] == LAST_SLOT) ? '0 : head_ff[q] + 1'b1;
            count_in[q] = count_ff[q] - 1'b1;
         end
         if (push[q]) begin
            tail_in[q]  = (tail_ff[q] == LAST_SLOT) ? '0 : tail_ff[q] + 1'b1;
            count_in[q] = count_ff[q] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         owner_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < 2; q++) begin
            head_ff[q]  <= '0;
            tail_ff[q]  <= '0;
            count_ff[q] <= '0;
         end
      end else begin
         busy_ff  <= busy_in;
         owner_ff <= owner_in;
         for (int q = 0; q < 2; q++) begin
            head_ff[q]  <= head_in[q];
            tail_ff[q]  <= tail_in[q];
            count_ff[q] <= count_in[q];
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: hold while stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // FIFO memories: write at the tail, read the next head into a register.
   // Forward the write data when it lands on the slot about to become head.
   always_ff @(posedge clock) begin
      for (int q = 0; q < 2; q++) begin
         if (push[q]) begin
            queue_mem_ff[q][tail_ff[q]] <= id_stored;
         end
         if (push[q] && (tail_ff[q] == head_in[q])) begin
            head_data_ff[q] <= id_stored;
         end else begin
            head_data_ff[q] <= queue_mem_ff[q][head_in[q]];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_ff};

endmodule

// ----- test/two_class_alternating_arbiter_tb.sv -----
// Self-checking testbench for the two-class alternating arbiter.
// It drives request/release transfers, predicts each result and compares them field by field.
// Depends on tcaa_pkg and two_class_alternating_arbiter.
module two_class_alternating_arbiter_tb;
   import tcaa_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int ID_BITS        = 8;
   localparam int RANDOM_ITEMS   = 850;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   // Tracks the arbiter's state alongside the block and holds the results still owed.
   class grant_ledger;
      bit                busy;
      bit                owner_cat;
      bit [ID_W-1:0]     waiting_zero[$];
      bit [ID_W-1:0]     waiting_one[$];
      result_type        owed_results[$];
      int unsigned       mismatches;

      function int unsigned queued(bit cat);
         return cat ? waiting_one.size() : waiting_zero.size();
      endfunction

      function int unsigned outstanding();
         return owed_results.size();
      endfunction

      // Apply one accepted transfer to the tracked state and queue its result.
      function void note_transfer(logic kind, logic cat, logic [ID_W-1:0] id);
         result_type want;
         bit         heir;
         want = '0;
         if (kind == KIND_REQUEST) begin
            if (!busy) begin
               busy = 1'b1;
               owner_cat = cat;
               want.grant_valid = 1'b1;
               want.grant_id = id;
               want.grant_category = cat;
            end else if (queued(cat) >= QUEUE_DEPTH) begin
               want.rejected = 1'b1;
            end else if (cat) begin
               waiting_one.push_back(id);
            end else begin
               waiting_zero.push_back(id);
            end
         end else if (!busy) begin
            want.release_error = 1'b1;
         end else if (queued(!owner_cat) > 0 || queued(owner_cat) > 0) begin
            // the other class goes first, the holder's own class only when the other is empty
            heir = (queued(!owner_cat) > 0) ? !owner_cat : owner_cat;
            owner_cat = heir;
            want.grant_valid = 1'b1;
            want.grant_category = heir;
            want.grant_id = heir ? waiting_one.pop_front() : waiting_zero.pop_front();
         end else begin
            busy = 1'b0;
         end
         if (!busy)
            want.holder_state = HOLDER_FREE;
         else
            want.holder_state = owner_cat ? HOLDER_CAT1 : HOLDER_CAT0;
         owed_results.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_results.size() == 0) begin
            $error("result transfer with nothing outstanding: %h", got);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         compare_field("grant_valid", want.grant_valid, got.grant_valid);
         compare_field("grant_id", want.grant_id, got.grant_id);
         compare_field("grant_category", want.grant_category, got.grant_category);
         compare_field("rejected", want.rejected, got.rejected);
         compare_field("release_error", want.release_error, got.release_error);
         compare_field("holder_state", want.holder_state, got.holder_state);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // [0] request_category, [8:1] requester_id
   logic                  req_tuser;    // [0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] grant_valid, [8:1] grant_id, [9] grant_category, [10] rejected,
   // [11] release_error, [13:12] holder_state
   logic [RSP_DATA_W-1:0] rsp_tdata;

   grant_ledger ledger = new();
   int unsigned quiet_cycles;

   two_class_alternating_arbiter #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_BITS    (ID_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Drop tvalid for the requested pause; a zero gap keeps it high so transfers run back to back.
   task automatic pause_sender(int unsigned cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Present one item and hold it until the transfer completes, then record it.
   // tready is read straight after the edge, so it still holds its pre-edge value.
   task automatic send_item(logic kind, logic cat, logic [ID_W-1:0] id);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - ID_W - 1){1'b0}}, id, cat};
      do @(posedge clock); while (!req_tready);
      ledger.note_transfer(kind, cat, id);
   endtask

   // Result side: stall at random, in calm and busy stretches, and check every transfer.
   task automatic absorb_results();
      int unsigned stall;
      int unsigned stretch_left;
      bit          calm;
      stretch_left = 0;
      calm = 1'b0;
      forever begin
         if (stretch_left == 0) begin
            calm = $urandom_range(0, 2) == 0;
            stretch_left = $urandom_range(10, 60);
         end
         stretch_left--;
         stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         ledger.check_result(result_type'(rsp_tdata[$bits(result_type)-1:0]));
      end
   endtask

   // Walk through the special cases: release while free, release emptying the resource,
   // hand-off within one class, a full FIFO with a rejection, and alternation between classes.
   task automatic run_directed();
      logic [3:0] n;
      pause_sender($urandom_range(0, 6));
      send_item(KIND_RELEASE, 1'b0, 8'h00);
      pause_sender($urandom_range(0, 6));
      send_item(KIND_REQUEST, 1'b1, 8'hFF);
      pause_sender($urandom_range(0, 6));
      send_item(KIND_RELEASE, 1'b1, 8'hFF);
      pause_sender($urandom_range(0, 6));
      send_item(KIND_REQUEST, 1'b0, 8'h00);
      pause_sender($urandom_range(0, 6));
      send_item(KIND_REQUEST, 1'b0, 8'h33);
      pause_sender($urandom_range(0, 6));
      send_item(KIND_RELEASE, 1'b0, 8'h00);
      // fill the class-one FIFO to the brim, then overflow it once
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         n = i[3:0];
         pause_sender($urandom_range(0, 6));
         send_item(KIND_REQUEST, 1'b1, {n, ~n});
      end
      pause_sender($urandom_range(0, 6));
      send_item(KIND_REQUEST, 1'b1, 8'hA5);
      pause_sender($urandom_range(0, 6));
      send_item(KIND_RELEASE, 1'b0, 8'h00);
      pause_sender($urandom_range(0, 6));
      send_item(KIND_RELEASE, 1'b1, 8'h00);
   endtask

   // Random phases: request-heavy ones fill the FIFOs, release-heavy ones drain them
   // back to free. Each phase picks its own class mix and whether the sender idles.
   task automatic run_random();
      int unsigned sent;
      int unsigned phase_len;
      int unsigned req_pct;
      int unsigned cat1_pct;
      bit          idling;
      bit          held_back;
      logic        kind;
      logic        cat;
      logic [ID_W-1:0] id;
      sent = 0;
      held_back = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: req_pct = 85;
            1: req_pct = 55;
            default: req_pct = 30;
         endcase
         cat1_pct = $urandom_range(0, 100);
         idling = $urandom_range(0, 2) != 0;
         // once, mid-run: hold the sender until every owed result has been drained
         if (!held_back && sent >= RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            while (ledger.outstanding() != 0) @(posedge clock);
            held_back = 1'b1;
         end
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            pause_sender(idling ? $urandom_range(0, 6) : 0);
            kind = ($urandom_range(1, 100) <= req_pct) ? KIND_REQUEST : KIND_RELEASE;
            cat = $urandom_range(1, 100) <= cat1_pct;
            if ($urandom_range(0, 9) == 0)
               id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
               id = ID_W'($urandom_range(0, 255));
            send_item(kind, cat, id);
            sent++;
         end
      end
   endtask

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_REQUEST;
      rsp_tready <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fork
         absorb_results();
      join_none
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      // wait for the last owed result, then give any stray result time to show up
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
